[hdl/cir_pkg.sv]
// ----------------------------------------------------------------------------
// cir_pkg
// Shared types, constants and helpers for the contact impulse resolver:
// fixed-point format, command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cir_pkg;

   // fraction bits of the signed fixed-point velocity/mass/depth format
   localparam int FRAC_BITS = 16;

   // restitution unity in Q1.16
   localparam logic [16:0] BOUNCE_ONE = 17'd65536;

   // shared divider: magnitude of the impulse numerator is 35 bits before scaling
   localparam int DIV_NUM_W = 35 + FRAC_BITS;
   localparam int DIV_DEN_W = 33;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   // shared multiplier operand widths
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 33;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   typedef enum logic [2:0] {
      MUL_DOT,
      MUL_JM,
      MUL_IMP,
      MUL_S,
      MUL_DV,
      MUL_P
   } mul_op_type;

   typedef enum logic [2:0] {
      WB_NONE,
      WB_ACC_CLR,
      WB_ACC_ADD,
      WB_JNUM,
      WB_IMP,
      WB_S,
      WB_NV,
      WB_C
   } wb_op_type;

   typedef struct packed {
      mul_op_type mul_op;
      logic [1:0] mul_k;
      wb_op_type  wb_op;
      logic [1:0] wb_k;
      logic       body;
      logic       cap_a;
      logic       cap_b;
      logic       ld_vn;
      logic       div_start;
      logic       div_ratio;
      logic       ld_j;
      logic       ld_ratio;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

   function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
      if (v > 72'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -72'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

[hdl/cir_div.sv]
// ----------------------------------------------------------------------------
// cir_div
// Unsigned restoring divider, one quotient bit per cycle. Denominator must
// stay stable while running; done pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
module cir_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [cir_pkg::DIV_NUM_W-1:0]  num,
   input  logic [cir_pkg::DIV_DEN_W-1:0]  den,
   output logic                           done,
   output logic [cir_pkg::DIV_NUM_W-1:0]  quot
);

   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [cir_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [cir_pkg::DIV_DEN_W:0]   rem_ff, rem_in;
   logic [cir_pkg::DIV_NUM_W-1:0] quot_ff, quot_in;
   logic [cir_pkg::DIV_DEN_W:0]   rem_sh;
   logic                          fits;

   always_comb begin
      rem_sh  = {rem_ff[cir_pkg::DIV_DEN_W-1:0], quot_ff[cir_pkg::DIV_NUM_W-1]};
      fits    = rem_sh >= {1'b0, den};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = cir_pkg::DIV_CNT_W'(cir_pkg::DIV_NUM_W - 1);
         rem_in  = '0;
         quot_in = num;
      end else if (run_ff) begin
         rem_in  = fits ? rem_sh - {1'b0, den} : rem_sh;
         quot_in = {quot_ff[cir_pkg::DIV_NUM_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

[hdl/cir_ctrl.sv]
// ----------------------------------------------------------------------------
// cir_ctrl
// Sequencer for the resolver: pairs up beats, steps the shared multiplier
// and divider through the impulse and correction math, hands out results.
// ----------------------------------------------------------------------------
module cir_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_is_second,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  cir_pkg::status_type status,
   output cir_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_DOT0, S_DOT1, S_DOT2, S_DOTW, S_VN, S_JM, S_JW, S_JDIV, S_JWAIT,
      S_IMP0, S_IMP1, S_IMP2, S_IMPW, S_RDIV, S_RWAIT, S_SM, S_SW, S_DV, S_P,
      S_PW, S_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] k_ff, k_in;
   logic       body_ff, body_in;
   logic       have_first_ff, have_first_in;
   logic       accept;

   always_comb begin
      accept        = req_valid && (state_ff == S_IDLE);
      state_in      = state_ff;
      k_in          = k_ff;
      body_in       = body_ff;
      have_first_in = have_first_ff;
      cmd           = '0;
      cmd.mul_op    = cir_pkg::MUL_DOT;
      cmd.wb_op     = cir_pkg::WB_NONE;
      cmd.body      = body_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!req_is_second) begin
                  cmd.cap_a     = 1'b1;
                  have_first_in = 1'b1;
               end else if (have_first_ff) begin
                  cmd.cap_b     = 1'b1;
                  have_first_in = 1'b0;
                  state_in      = S_DOT0;
               end
            end
         end
         S_DOT0: begin
            cmd.mul_k = 2'd0;
            state_in  = S_DOT1;
         end
         S_DOT1: begin
            cmd.mul_k = 2'd1;
            cmd.wb_op = cir_pkg::WB_ACC_CLR;
            state_in  = S_DOT2;
         end
         S_DOT2: begin
            cmd.mul_k = 2'd2;
            cmd.wb_op = cir_pkg::WB_ACC_ADD;
            state_in  = S_DOTW;
         end
         S_DOTW: begin
            cmd.wb_op = cir_pkg::WB_ACC_ADD;
            state_in  = S_VN;
         end
         S_VN: begin
            cmd.ld_vn = 1'b1;
            state_in  = S_JM;
         end
         S_JM: begin
            cmd.mul_op = cir_pkg::MUL_JM;
            state_in   = S_JW;
         end
         S_JW: begin
            cmd.wb_op = cir_pkg::WB_JNUM;
            state_in  = S_JDIV;
         end
         S_JDIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_JWAIT;
         end
         S_JWAIT: begin
            if (status.div_done) begin
               cmd.ld_j = 1'b1;
               state_in = S_IMP0;
            end
         end
         S_IMP0: begin
            cmd.mul_op = cir_pkg::MUL_IMP;
            cmd.mul_k  = 2'd0;
            state_in   = S_IMP1;
         end
         S_IMP1: begin
            cmd.mul_op = cir_pkg::MUL_IMP;
            cmd.mul_k  = 2'd1;
            cmd.wb_op  = cir_pkg::WB_IMP;
            cmd.wb_k   = 2'd0;
            state_in   = S_IMP2;
         end
         S_IMP2: begin
            cmd.mul_op = cir_pkg::MUL_IMP;
            cmd.mul_k  = 2'd2;
            cmd.wb_op  = cir_pkg::WB_IMP;
            cmd.wb_k   = 2'd1;
            state_in   = S_IMPW;
         end
         S_IMPW: begin
            cmd.wb_op = cir_pkg::WB_IMP;
            cmd.wb_k  = 2'd2;
            body_in   = 1'b0;
            state_in  = S_RDIV;
         end
         S_RDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_ratio = 1'b1;
            state_in      = S_RWAIT;
         end
         S_RWAIT: begin
            cmd.div_ratio = 1'b1;
            if (status.div_done) begin
               cmd.ld_ratio = 1'b1;
               state_in     = S_SM;
            end
         end
         S_SM: begin
            cmd.mul_op = cir_pkg::MUL_S;
            state_in   = S_SW;
         end
         S_SW: begin
            cmd.wb_op = cir_pkg::WB_S;
            k_in      = 2'd0;
            state_in  = S_DV;
         end
         S_DV: begin
            cmd.mul_op = cir_pkg::MUL_DV;
            cmd.mul_k  = k_ff;
            state_in   = S_P;
         end
         S_P: begin
            cmd.mul_op = cir_pkg::MUL_P;
            cmd.mul_k  = k_ff;
            cmd.wb_op  = cir_pkg::WB_NV;
            cmd.wb_k   = k_ff;
            state_in   = S_PW;
         end
         S_PW: begin
            cmd.wb_op = cir_pkg::WB_C;
            cmd.wb_k  = k_ff;
            if (k_ff == 2'd2) begin
               state_in = S_OUT;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_DV;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               if (!body_ff) begin
                  body_in  = 1'b1;
                  state_in = S_RDIV;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         k_ff          <= 2'd0;
         body_ff       <= 1'b0;
         have_first_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         k_ff          <= k_in;
         body_ff       <= body_in;
         have_first_ff <= have_first_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_OUT;

`ifndef ASSERT_OFF
   a_out_blocks_in: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result is pending");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == S_JWAIT || state_ff == S_RWAIT))
      else $error("divider finished outside a wait state");

   a_pair_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !rsp_stall && body_ff) |=> state_ff == S_IDLE)
      else $error("second result did not close the pair");
`endif

endmodule

[hdl/cir_dpath.sv]
// ----------------------------------------------------------------------------
// cir_dpath
// Datapath: held body records, shared multiplier with product register,
// shared divider, and the result registers for one body at a time.
// ----------------------------------------------------------------------------
module cir_dpath (
   input  logic                clock,
   input  logic                reset,
   input  cir_pkg::cmd_type    cmd,
   output cir_pkg::status_type status,
   input  logic signed [31:0]  req_vel_x,
   input  logic signed [31:0]  req_vel_y,
   input  logic signed [31:0]  req_vel_z,
   input  logic [16:0]         req_bounce,
   input  logic [31:0]         req_inv_mass,
   input  logic                req_movable,
   input  logic signed [17:0]  req_normal_x,
   input  logic signed [17:0]  req_normal_y,
   input  logic signed [17:0]  req_normal_z,
   input  logic [30:0]         req_depth,
   output logic signed [31:0]  rsp_new_vel_x,
   output logic signed [31:0]  rsp_new_vel_y,
   output logic signed [31:0]  rsp_new_vel_z,
   output logic signed [31:0]  rsp_corr_x,
   output logic signed [31:0]  rsp_corr_y,
   output logic signed [31:0]  rsp_corr_z,
   output logic                rsp_updated,
   output logic                rsp_grounded
);

   // held body A, captured body B and contact
   logic signed [31:0] a_vel_ff [3];
   logic [16:0]        a_bounce_ff;
   logic [31:0]        a_inv_ff;
   logic               a_mov_ff;
   logic signed [31:0] b_vel_ff [3];
   logic [16:0]        b_bounce_ff;
   logic [31:0]        b_inv_ff;
   logic               b_mov_ff;
   logic signed [17:0] n_ff [3];
   logic [30:0]        depth_ff;

   // intermediate results
   logic signed [cir_pkg::PROD_W-1:0]  prod_ff;
   logic signed [52:0]                 acc_ff;
   logic signed [31:0]                 vn_ff;
   logic signed [34:0]                 jnum_ff;
   logic signed [31:0]                 j_ff;
   logic signed [31:0]                 imp_ff [3];
   logic [cir_pkg::FRAC_BITS:0]        ratio_ff;
   logic [30:0]                        s_ff;
   logic signed [31:0]                 nv_ff [3];
   logic signed [31:0]                 c_ff [3];

   logic [16:0]                        e_min;
   logic [16:0]                        e_val;
   logic [17:0]                        one_plus_e;
   logic [32:0]                        inv_sum;
   logic                               upd_a;
   logic                               upd_b;
   logic                               upd;
   logic [31:0]                        own;
   logic signed [31:0]                 v_sel;
   logic signed [cir_pkg::MUL_A_W-1:0] mul_a;
   logic signed [cir_pkg::MUL_B_W-1:0] mul_b;
   logic signed [cir_pkg::PROD_W-1:0]  prod_sh;
   logic signed [cir_pkg::PROD_W-1:0]  jm_sh;
   logic [34:0]                        j_abs;
   logic [cir_pkg::DIV_NUM_W-1:0]      div_num;
   logic [cir_pkg::DIV_NUM_W-1:0]      div_quot;
   logic                               div_done;
   logic signed [71:0]                 q_ext;
   logic signed [71:0]                 nv_sum;
   logic signed [71:0]                 p_ext;

   always_comb begin
      e_min      = (a_bounce_ff < b_bounce_ff) ? a_bounce_ff : b_bounce_ff;
      e_val      = (e_min > cir_pkg::BOUNCE_ONE) ? cir_pkg::BOUNCE_ONE : e_min;
      one_plus_e = 18'(cir_pkg::BOUNCE_ONE) + {1'b0, e_val};
      inv_sum    = (a_mov_ff ? {1'b0, a_inv_ff} : 33'd0)
                 + (b_mov_ff ? {1'b0, b_inv_ff} : 33'd0);
      upd_a      = a_mov_ff && (inv_sum != 33'd0);
      upd_b      = b_mov_ff && (inv_sum != 33'd0);
      upd        = cmd.body ? upd_b : upd_a;
      own        = cmd.body ? b_inv_ff : a_inv_ff;
      v_sel      = cmd.body ? b_vel_ff[cmd.wb_k] : a_vel_ff[cmd.wb_k];
   end

   // shared multiplier operand select
   always_comb begin
      case (cmd.mul_op)
         cir_pkg::MUL_DOT: begin
            mul_a = 34'(a_vel_ff[cmd.mul_k]) - 34'(b_vel_ff[cmd.mul_k]);
            mul_b = 33'(n_ff[cmd.mul_k]);
         end
         cir_pkg::MUL_JM: begin
            mul_a = 34'(vn_ff);
            mul_b = $signed({15'b0, one_plus_e});
         end
         cir_pkg::MUL_IMP: begin
            mul_a = 34'(j_ff);
            mul_b = 33'(n_ff[cmd.mul_k]);
         end
         cir_pkg::MUL_S: begin
            mul_a = $signed({3'b0, depth_ff});
            mul_b = $signed({{(cir_pkg::MUL_B_W - cir_pkg::FRAC_BITS - 1){1'b0}}, ratio_ff});
         end
         cir_pkg::MUL_DV: begin
            mul_a = $signed({2'b0, own});
            mul_b = 33'(imp_ff[cmd.mul_k]);
         end
         cir_pkg::MUL_P: begin
            mul_a = $signed({3'b0, s_ff});
            mul_b = 33'(n_ff[cmd.mul_k]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      prod_sh = prod_ff >>> cir_pkg::FRAC_BITS;
      // Q2.16 one-plus-restitution factor
      jm_sh   = prod_ff >>> 16;
      j_abs   = jnum_ff[34] ? 35'(-jnum_ff) : 35'(jnum_ff);
      div_num = cmd.div_ratio ? {3'b0, own, {cir_pkg::FRAC_BITS{1'b0}}}
                              : {j_abs, {cir_pkg::FRAC_BITS{1'b0}}};
      q_ext   = $signed(72'({1'b0, div_quot}));
      nv_sum  = cmd.body ? 72'(v_sel) - 72'(prod_sh) : 72'(v_sel) + 72'(prod_sh);
      p_ext   = cmd.body ? -72'(prod_ff) : 72'(prod_ff);
   end

   cir_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (inv_sum),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign status.div_done = div_done;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.cap_a) begin
         a_vel_ff[0] <= req_vel_x;
         a_vel_ff[1] <= req_vel_y;
         a_vel_ff[2] <= req_vel_z;
         a_bounce_ff <= req_bounce;
         a_inv_ff    <= req_inv_mass;
         a_mov_ff    <= req_movable;
      end
      if (cmd.cap_b) begin
         b_vel_ff[0] <= req_vel_x;
         b_vel_ff[1] <= req_vel_y;
         b_vel_ff[2] <= req_vel_z;
         b_bounce_ff <= req_bounce;
         b_inv_ff    <= req_inv_mass;
         b_mov_ff    <= req_movable;
         n_ff[0]     <= req_normal_x;
         n_ff[1]     <= req_normal_y;
         n_ff[2]     <= req_normal_z;
         depth_ff    <= req_depth;
      end
      if (cmd.ld_vn) begin
         vn_ff <= cir_pkg::sat32(72'(acc_ff >>> cir_pkg::FRAC_BITS));
      end
      if (cmd.ld_j) begin
         if (inv_sum == 33'd0) begin
            j_ff <= '0;
         end else begin
            // divider works on magnitudes, quotient truncates toward zero
            j_ff <= cir_pkg::sat32(jnum_ff[34] ? -q_ext : q_ext);
         end
      end
      if (cmd.ld_ratio) begin
         ratio_ff <= div_quot[cir_pkg::FRAC_BITS:0];
      end
      case (cmd.wb_op)
         cir_pkg::WB_ACC_CLR: begin
            acc_ff <= $signed(prod_ff[52:0]);
         end
         cir_pkg::WB_ACC_ADD: begin
            acc_ff <= acc_ff + $signed(prod_ff[52:0]);
         end
         cir_pkg::WB_JNUM: begin
            jnum_ff <= 35'(-jm_sh);
         end
         cir_pkg::WB_IMP: begin
            imp_ff[cmd.wb_k] <= cir_pkg::sat32(72'(prod_sh));
         end
         cir_pkg::WB_S: begin
            s_ff <= prod_ff[cir_pkg::FRAC_BITS+30:cir_pkg::FRAC_BITS];
         end
         cir_pkg::WB_NV: begin
            nv_ff[cmd.wb_k] <= upd ? cir_pkg::sat32(nv_sum) : v_sel;
         end
         cir_pkg::WB_C: begin
            c_ff[cmd.wb_k] <= upd ? cir_pkg::sat32(p_ext >>> cir_pkg::FRAC_BITS) : 32'sd0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_new_vel_x = nv_ff[0];
   assign rsp_new_vel_y = nv_ff[1];
   assign rsp_new_vel_z = nv_ff[2];
   assign rsp_corr_x    = c_ff[0];
   assign rsp_corr_y    = c_ff[1];
   assign rsp_corr_z    = c_ff[2];
   assign rsp_updated   = upd;
   assign rsp_grounded  = cmd.body ? (n_ff[1] < 18'sd0) : (n_ff[1] > 18'sd0);

endmodule

[hdl/contact_impulse_resolver.sv]
// A first beat (body A) is taken and only held.
// The A result is offered after the second beat is taken, the B result
// after the A result is taken.
// The shared divider runs three times per pair, for 51 quotient bits each.
// Synchronous reset returns to idle and drops any held first beat.
// ----------------------------------------------------------------------------
// contact_impulse_resolver
// Impulse-based contact response for a pair of rigid bodies in signed fixed
// point: new velocities and positional correction for both bodies.
// ----------------------------------------------------------------------------
module contact_impulse_resolver (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_is_second,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic [16:0]        req_bounce,
   input  logic [31:0]        req_inv_mass,
   input  logic               req_movable,
   input  logic signed [17:0] req_normal_x,
   input  logic signed [17:0] req_normal_y,
   input  logic signed [17:0] req_normal_z,
   input  logic [30:0]        req_depth,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_which_body,
   output logic signed [31:0] rsp_new_vel_x,
   output logic signed [31:0] rsp_new_vel_y,
   output logic signed [31:0] rsp_new_vel_z,
   output logic signed [31:0] rsp_corr_x,
   output logic signed [31:0] rsp_corr_y,
   output logic signed [31:0] rsp_corr_z,
   output logic               rsp_updated,
   output logic               rsp_grounded,
   output logic               rsp_last
);

   cir_pkg::cmd_type    cmd;
   cir_pkg::status_type status;

   cir_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_is_second (req_is_second),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .cmd           (cmd)
   );

   cir_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_vel_x     (req_vel_x),
      .req_vel_y     (req_vel_y),
      .req_vel_z     (req_vel_z),
      .req_bounce    (req_bounce),
      .req_inv_mass  (req_inv_mass),
      .req_movable   (req_movable),
      .req_normal_x  (req_normal_x),
      .req_normal_y  (req_normal_y),
      .req_normal_z  (req_normal_z),
      .req_depth     (req_depth),
      .rsp_new_vel_x (rsp_new_vel_x),
      .rsp_new_vel_y (rsp_new_vel_y),
      .rsp_new_vel_z (rsp_new_vel_z),
      .rsp_corr_x    (rsp_corr_x),
      .rsp_corr_y    (rsp_corr_y),
      .rsp_corr_z    (rsp_corr_z),
      .rsp_updated   (rsp_updated),
      .rsp_grounded  (rsp_grounded)
   );

   assign rsp_which_body = cmd.body;
   assign rsp_last       = cmd.body;

endmodule

[bench/contact_impulse_resolver_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contact_impulse_resolver_test
// Drives body A / body B beat pairs with random gaps and response stalls,
// predicts both velocity/correction results per contact in a scoreboard
// class and checks every result beat field by field, in order.
// ----------------------------------------------------------------------------
module contact_impulse_resolver_test;

   typedef struct {
      bit                 is_second;
      logic signed [31:0] vel [3];
      logic [16:0]        bounce;
      logic [31:0]        inv_mass;
      bit                 movable;
      logic signed [17:0] normal [3];
      logic [30:0]        depth;
   } contact_beat;

   typedef struct {
      bit                 which_body;
      logic signed [31:0] new_vel [3];
      logic signed [31:0] corr [3];
      bit                 updated;
      bit                 grounded;
      bit                 last;
   } body_result;

   class impulse_scoreboard;
      bit                 have_body_a;
      logic signed [31:0] held_vel [3];
      logic [16:0]        held_bounce;
      logic [31:0]        held_inv_mass;
      bit                 held_movable;
      body_result         expected_results [$];
      int                 mismatches;
      int                 results_seen;

      static function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void note_beat(contact_beat b);
         longint va [3], vb [3], n [3], imp [3];
         longint dot, vn, jnum, j, e, inva, invb, invsum, depth;
         longint own, ratio, s, nv, dv, p, c;
         bit dyn_a, dyn_b, upd;
         body_result res;
         if (!b.is_second) begin
            held_vel = b.vel;
            held_bounce = b.bounce;
            held_inv_mass = b.inv_mass;
            held_movable = b.movable;
            have_body_a = 1'b1;
            return;
         end
         // second beat with no body A held is dropped by the block
         if (!have_body_a) return;
         have_body_a = 1'b0;
         for (int k = 0; k < 3; k++) begin
            va[k] = longint'(held_vel[k]);
            vb[k] = longint'(b.vel[k]);
            n[k] = longint'(b.normal[k]);
         end
         inva = longint'(held_inv_mass);
         invb = longint'(b.inv_mass);
         dyn_a = held_movable;
         dyn_b = b.movable;
         depth = longint'(b.depth);
         e = longint'((held_bounce < b.bounce) ? held_bounce : b.bounce);
         if (e > 65536) e = 65536;
         invsum = (dyn_a ? inva : 0) + (dyn_b ? invb : 0);
         dot = 0;
         for (int k = 0; k < 3; k++) dot += (va[k] - vb[k]) * n[k];
         vn = clamp32(dot >>> cir_pkg::FRAC_BITS);
         jnum = -(((65536 + e) * vn) >>> 16);
         j = (invsum != 0) ? clamp32((jnum * (64'sd1 << cir_pkg::FRAC_BITS)) / invsum) : 0;
         for (int k = 0; k < 3; k++) imp[k] = clamp32((j * n[k]) >>> cir_pkg::FRAC_BITS);
         for (int r = 0; r < 2; r++) begin
            upd = (r == 0 ? dyn_a : dyn_b) && invsum != 0;
            own = (r == 0) ? inva : invb;
            ratio = 0;
            s = 0;
            if (upd) begin
               ratio = (own << cir_pkg::FRAC_BITS) / invsum;
               s = (ratio * depth) >> cir_pkg::FRAC_BITS;
            end
            res.which_body = r[0];
            for (int k = 0; k < 3; k++) begin
               nv = (r == 0) ? va[k] : vb[k];
               c = 0;
               if (upd) begin
                  dv = (own * imp[k]) >>> cir_pkg::FRAC_BITS;
                  p = n[k] * s;
                  nv = clamp32(r == 0 ? nv + dv : nv - dv);
                  c = clamp32((r == 0 ? p : -p) >>> cir_pkg::FRAC_BITS);
               end
               res.new_vel[k] = nv[31:0];
               res.corr[k] = c[31:0];
            end
            res.updated = upd;
            res.grounded = (r == 0) ? (n[1] > 0) : (n[1] < 0);
            res.last = r[0];
            expected_results = {expected_results, res};
         end
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d: %s expected %h got %h", results_seen, name, exp_v,
                        act_v);
         end
      endfunction

      function void check_result(body_result got);
         body_result exp_r;
         results_seen++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result %0d: unexpected beat", results_seen);
            return;
         end
         exp_r = expected_results.pop_front();
         compare_field("which_body", exp_r.which_body, got.which_body);
         for (int k = 0; k < 3; k++) begin
            compare_field($sformatf("new_vel[%0d]", k), exp_r.new_vel[k], got.new_vel[k]);
            compare_field($sformatf("corr[%0d]", k), exp_r.corr[k], got.corr[k]);
         end
         compare_field("updated", exp_r.updated, got.updated);
         compare_field("grounded", exp_r.grounded, got.grounded);
         compare_field("last", exp_r.last, got.last);
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_is_second = 1'b0;
   logic signed [31:0] req_vel_x = '0, req_vel_y = '0, req_vel_z = '0;
   logic [16:0]        req_bounce = '0;
   logic [31:0]        req_inv_mass = '0;
   logic               req_movable = 1'b0;
   logic signed [17:0] req_normal_x = '0, req_normal_y = '0, req_normal_z = '0;
   logic [30:0]        req_depth = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_which_body;
   logic signed [31:0] rsp_new_vel_x, rsp_new_vel_y, rsp_new_vel_z;
   logic signed [31:0] rsp_corr_x, rsp_corr_y, rsp_corr_z;
   logic               rsp_updated, rsp_grounded, rsp_last;

   impulse_scoreboard sb = new();
   contact_beat       beats [$];

   contact_impulse_resolver u_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void add_beat(contact_beat b);
      beats = {beats, b};
   endfunction

   function automatic logic signed [31:0] rand_vel();
      if ($urandom_range(3) == 0) return $urandom;
      return $signed($urandom_range(1 << 20)) - (1 << 19);
   endfunction

   function automatic contact_beat rand_beat(bit second);
      contact_beat b;
      int axis;
      b.is_second = second;
      for (int k = 0; k < 3; k++) b.vel[k] = rand_vel();
      b.bounce = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
      case ($urandom_range(7))
         0: b.inv_mass = $urandom;
         1: b.inv_mass = 32'd0;
         default: b.inv_mass = $urandom_range(4 << 16);
      endcase
      b.movable = $urandom_range(4) != 0;
      axis = $urandom_range(2);
      for (int k = 0; k < 3; k++) begin
         if ($urandom_range(1) == 0)
            b.normal[k] = (k == axis) ? ($urandom_range(1) ? 18'sd65536 : -18'sd65536)
                                      : 18'sd0;
         else
            b.normal[k] = 18'($signed($urandom_range(131072)) - 65536);
      end
      b.depth = ($urandom_range(7) == 0) ? 31'($urandom) : 31'($urandom_range(1 << 18));
      return b;
   endfunction

   function automatic contact_beat make_beat(bit second, longint vx, longint vy, longint vz,
                                             int bounce, longint inv_mass, bit movable,
                                             int nx, int ny, int nz, longint depth);
      contact_beat b;
      b.is_second = second;
      b.vel[0] = 32'(vx);
      b.vel[1] = 32'(vy);
      b.vel[2] = 32'(vz);
      b.bounce = 17'(bounce);
      b.inv_mass = 32'(inv_mass);
      b.movable = movable;
      b.normal[0] = 18'(nx);
      b.normal[1] = 18'(ny);
      b.normal[2] = 18'(nz);
      b.depth = 31'(depth);
      return b;
   endfunction

   function automatic int rand_gap(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 4);
      return $urandom_range(20, 250);
   endfunction

   task automatic drive_beat(contact_beat b);
      req_is_second <= b.is_second;
      req_vel_x <= b.vel[0];
      req_vel_y <= b.vel[1];
      req_vel_z <= b.vel[2];
      req_bounce <= b.bounce;
      req_inv_mass <= b.inv_mass;
      req_movable <= b.movable;
      req_normal_x <= b.normal[0];
      req_normal_y <= b.normal[1];
      req_normal_z <= b.normal[2];
      req_depth <= b.depth;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_beat(b);
   endtask

   always @(posedge clock) begin
      body_result got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.which_body = rsp_which_body;
         got.new_vel = '{rsp_new_vel_x, rsp_new_vel_y, rsp_new_vel_z};
         got.corr = '{rsp_corr_x, rsp_corr_y, rsp_corr_z};
         got.updated = rsp_updated;
         got.grounded = rsp_grounded;
         got.last = rsp_last;
         sb.check_result(got);
      end
   end

   // response side: short stalls, quiet stretches and one long hold-off
   initial begin
      int  run;
      int  r;
      bit  level;
      bit  held_off;
      run = 0;
      level = 1'b0;
      held_off = 1'b0;
      forever begin
         @(negedge clock);
         if (run == 0) begin
            r = $urandom_range(99);
            if (!held_off && sb.results_seen >= 150) begin
               held_off = 1'b1;
               level = 1'b1;
               run = 900;
            end else if (r < 50) begin
               level = 1'b0;
               run = $urandom_range(1, 6);
            end else if (r < 62) begin
               level = 1'b0;
               run = $urandom_range(100, 400);
            end else if (r < 92) begin
               level = 1'b1;
               run = $urandom_range(1, 3);
            end else begin
               level = 1'b1;
               run = $urandom_range(10, 80);
            end
         end
         run--;
         rsp_stall <= level;
      end
   end

   initial begin
      #12_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int  kind;
      int  gap;
      bit  quiet;
      // directed: lone second, normal pair, static A, neither dynamic, zero masses
      add_beat(make_beat(1, 1 << 16, 0, 0, 30000, 1 << 16, 1, 0, 65536, 0, 1000));
      add_beat(make_beat(0, 2 << 16, -(1 << 16), 3, 40000, 1 << 16, 1, 0, 0, 0, 0));
      add_beat(make_beat(1, -(1 << 16), 1 << 16, 0, 20000, 2 << 16, 1,
                         0, 65536, 0, 1 << 14));
      add_beat(make_beat(0, 5 << 16, 0, 0, 65536, 1 << 16, 0, 0, 0, 0, 0));
      add_beat(make_beat(1, 0, -(3 << 16), 0, 65536, 1 << 15, 1,
                         65536, 0, 0, 1 << 16));
      add_beat(make_beat(0, 7 << 16, 1, 2, 1000, 1 << 16, 0, 0, 0, 0, 0));
      add_beat(make_beat(1, 0, 0, 0, 1000, 1 << 16, 0, 0, -65536, 0, 1 << 16));
      add_beat(make_beat(0, 7 << 16, 1, 2, 1000, 0, 1, 0, 0, 0, 0));
      add_beat(make_beat(1, -(4 << 16), 9, 0, 1000, 0, 1, 0, 0, 65536, 1 << 16));
      // bounce above one on both bodies
      add_beat(make_beat(0, 3 << 16, 3 << 16, 0, 131071, 1 << 16, 1, 0, 0, 0, 0));
      add_beat(make_beat(1, -(3 << 16), 0, 0, 100000, 3 << 16, 1,
                         46341, 46341, 0, 5 << 16));
      // repeated first replaces the held body
      add_beat(make_beat(0, 9 << 16, 0, 0, 65536, 1 << 16, 0, 0, 0, 0, 0));
      add_beat(make_beat(0, 1 << 16, 2 << 16, 0, 50000, 1 << 16, 1, 0, 0, 0, 0));
      add_beat(make_beat(1, 0, 0, 1 << 16, 50000, 1 << 16, 1, 0, 0, -65536, 100));
      // second after a consumed pair is dropped
      add_beat(make_beat(1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1));
      // extremes
      add_beat(make_beat(0, 32'h7FFFFFFF, -64'sd2147483648, 32'h7FFFFFFF, 0,
                         32'hFFFFFFFF, 1, 0, 0, 0, 0));
      add_beat(make_beat(1, -64'sd2147483648, 32'h7FFFFFFF, -64'sd2147483648, 0,
                         32'hFFFFFFFF, 1, 65536, -65536, 65536, 31'h7FFFFFFF));
      add_beat(make_beat(0, -64'sd2147483648, -64'sd2147483648, 0, 65536, 1, 1,
                         0, 0, 0, 0));
      add_beat(make_beat(1, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 65536,
                         32'hFFFFFFFF, 1, -65536, -65536, -65536, 31'h7FFFFFFF));
      add_beat(make_beat(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_beat(make_beat(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // random: mostly well-formed pairs, some broken sequences
      while (beats.size() < 1900) begin
         kind = $urandom_range(99);
         if (kind < 85) begin
            add_beat(rand_beat(0));
            add_beat(rand_beat(1));
         end else if (kind < 91) begin
            add_beat(rand_beat(0));
            add_beat(rand_beat(0));
            add_beat(rand_beat(1));
         end else begin
            add_beat(rand_beat(1));
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      quiet = 1'b0;
      foreach (beats[i]) begin
         @(negedge clock);
         if (i % 200 == 0) quiet = $urandom_range(2) == 0;
         gap = rand_gap(quiet);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         drive_beat(beats[i]);
      end
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (sb.mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
